// ===== hdl/handle_slot_table_core_assert.svh =====
// ============================================================================
// Handle slot table assertion macros
// Shared concurrent assertion wrappers for the handle slot table RTL.
// ============================================================================
`ifndef HANDLE_SLOT_TABLE_CORE_ASSERT_SVH
`define HANDLE_SLOT_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge, disabled while reset is low
`define HST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: when cond holds, prop must hold too
`define HST_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
    `HST_ASSERT(lbl, clk, rst_n, (cond) |-> (prop), msg)

`else

`define HST_ASSERT(lbl, clk, rst_n, prop, msg)
`define HST_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg)

`endif

`endif

// ===== hdl/hst_pkg.sv =====
// ============================================================================
// Handle slot table package
// Types, command and status codes, and default sizes shared by the controller, datapath, core and testbench.
// ============================================================================
package hst_pkg;

    // Default sizes
    localparam int SLOT_COUNT_DEF = 1024;
    localparam int ENTRY_BITS_DEF = 32;

    // Command codes
    localparam logic [1:0] CMD_STORE   = 2'd0;
    localparam logic [1:0] CMD_FIND    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] handle_index;
        logic [31:0] entry_value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [10:0] handle_out;
        logic [31:0] entry_out;
        logic [1:0]  status;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch item, issue memory reads
        logic commit;   // resolve item, write memories, load result
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy; // result register full and not taken this cycle
    } t_dp_status;

endpackage

// ===== hdl/hst_ram.sv =====
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ============================================================================
module hst_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hst_ctrl.sv =====
// ============================================================================
// Handle slot table controller
// Two-state sequencer: capture an item, then commit it once the result
// register can take the result.
// ============================================================================
module hst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hst_pkg::t_dp_status i_status,
    output hst_pkg::t_ctrl_cmd  o_cmd
);

    import hst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Handshake and commands
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.capture = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.commit  = (r_state == S_EXEC) && !i_status.out_busy;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (o_cmd.commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/hst_datapath.sv =====
// ============================================================================
// Handle slot table datapath
// Slot and free-stack memories, counters, item latch and result register.
// ============================================================================
`include "handle_slot_table_core_assert.svh"

module hst_datapath #(
    parameter int SLOT_COUNT = hst_pkg::SLOT_COUNT_DEF,
    parameter int ENTRY_BITS = hst_pkg::ENTRY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hst_pkg::t_in_item   i_in_item,
    input  hst_pkg::t_ctrl_cmd  i_cmd,
    output hst_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hst_pkg::t_out_item  o_out_item
);

    import hst_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // Latched item
    logic [1:0]            r_cmd;
    logic [11:0]           r_handle;
    logic [ENTRY_BITS-1:0] r_value;

    // Counters
    logic [CW-1:0] r_high_water, n_high_water;
    logic [CW-1:0] r_free_count, n_free_count;

    // Result register
    logic      r_out_valid;
    t_out_item r_out_item, n_out_item;

    // Memory ports
    logic                  slot_we, stack_we;
    logic [AW-1:0]         slot_waddr, slot_raddr, stack_waddr, stack_raddr;
    logic [ENTRY_BITS-1:0] slot_wdata, slot_rdata;
    logic [AW-1:0]         stack_wdata, stack_rdata;

    // Decode helpers
    logic          in_range, hit, pop, full, stack_room;
    logic [AW-1:0] store_slot, handle_slot;
    logic          want_slot_we, want_stack_we;

    // Slot read address comes straight from the item being captured; free-stack read address from the free count
    assign slot_raddr  = AW'(32'(i_in_item.handle_index) - 32'd1);
    assign stack_raddr = AW'(32'(r_free_count) - 32'd1);

    hst_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    hst_ram #(
        .WIDTH (AW),
        .DEPTH (SLOT_COUNT)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    // Item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_in_item.cmd;
            r_handle <= i_in_item.handle_index;
            r_value  <= ENTRY_BITS'(i_in_item.entry_value);
        end
    end

    // Handle checks and slot choice
    assign in_range    = (r_handle != 12'd0)
                      && (32'(r_handle) <= 32'(r_high_water))
                      && (32'(r_handle) <= SLOT_COUNT);
    assign hit         = in_range && (slot_rdata != '0);
    assign pop         = (r_free_count != '0);
    assign full        = !pop && (32'(r_high_water) == SLOT_COUNT);
    assign stack_room  = (32'(r_free_count) < SLOT_COUNT);
    assign store_slot  = pop ? stack_rdata : AW'(r_high_water);
    assign handle_slot = AW'(32'(r_handle) - 32'd1);

    // Command resolution
    always_comb begin
        n_high_water  = r_high_water;
        n_free_count  = r_free_count;
        want_slot_we  = 1'b0;
        want_stack_we = 1'b0;
        slot_waddr    = handle_slot;
        slot_wdata    = '0;
        stack_waddr   = AW'(r_free_count);
        stack_wdata   = handle_slot;
        n_out_item    = '{handle_out: '0, entry_out: '0, status: ST_NOT_FOUND};
        unique case (r_cmd) inside
            CMD_STORE: begin
                if (full) begin
                    n_out_item.status = ST_FULL;
                end else begin
                    want_slot_we          = 1'b1;
                    slot_waddr            = store_slot;
                    slot_wdata            = r_value;
                    n_out_item.handle_out = 11'(32'(store_slot) + 32'd1);
                    n_out_item.status     = ST_OK;
                    if (pop) begin
                        n_free_count = r_free_count - CW'(1);
                    end else begin
                        n_high_water = r_high_water + CW'(1);
                    end
                end
            end
            CMD_FIND, CMD_RELEASE: begin
                if (hit) begin
                    n_out_item.handle_out = 11'(r_handle);
                    n_out_item.entry_out  = 32'(slot_rdata);
                    n_out_item.status     = ST_OK;
                    // Release clears the slot and pushes its index
                    if ((r_cmd == CMD_RELEASE) && stack_room) begin
                        want_slot_we  = 1'b1;
                        want_stack_we = 1'b1;
                        n_free_count  = r_free_count + CW'(1);
                    end
                end
            end
            default: begin
                n_out_item.status = ST_NOT_FOUND;
            end
        endcase
    end

    assign slot_we  = i_cmd.commit && want_slot_we;
    assign stack_we = i_cmd.commit && want_stack_we;

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_water <= '0;
            r_free_count <= '0;
        end else if (i_cmd.commit) begin
            r_high_water <= n_high_water;
            r_free_count <= n_free_count;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

    // Checks
    `HST_ASSERT(a_free_le_hw, i_clk, i_rst_n, r_free_count <= r_high_water, "free count above high water")
    `HST_ASSERT(a_hw_bound, i_clk, i_rst_n, 32'(r_high_water) <= SLOT_COUNT, "high water above slot count")
    `HST_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.commit, !(r_out_valid && !i_out_ready), "result overwritten")
    `HST_ASSERT_IMP(a_commit_loads, i_clk, i_rst_n, i_cmd.commit, ##1 r_out_valid, "commit did not load result")

endmodule

// ===== hdl/handle_slot_table_core.sv =====
// ============================================================================
// Handle slot table core
// Maps one-based handles to entry words with a last-in first-out free list.
// ============================================================================
// On acceptance the block reads the slot memory and the free-stack memory;
// in the execute state it then resolves the command, writes both memories
// and loads the result register, once that register can take the result.
// An item is accepted while an earlier result still waits in the result
// register; the block then holds the second item until that result
// is taken. Store reuses the most recently released slot, else the next unused
// one, and reports full with handle 0 when neither exists. Find and release
// reject handle 0, handles above the high-water mark and empty (zero) slots.
// No clearing pass: both memories are read only where they have been written.
module handle_slot_table_core #(
    parameter int SLOT_COUNT = hst_pkg::SLOT_COUNT_DEF,
    parameter int ENTRY_BITS = hst_pkg::ENTRY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hst_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hst_pkg::t_out_item o_out_item
);

    import hst_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // Sequencer
    hst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    // Memories, counters and result register
    hst_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/handle_slot_table_core_check.sv =====
// ============================================================================
// Handle slot table result checker
// Watches both channels of the handle slot table. Every accepted input item
// is run through a local model of the slot memory, high-water mark and free
// stack, and the predicted result is queued. Every accepted result is compared
// field by field with the oldest queued prediction.
// ============================================================================
module handle_slot_table_core_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  hst_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  hst_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending
);
    import hst_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;

    // Model state
    logic [31:0] slot_words [SLOTS];
    logic [9:0]  freed_slots [SLOTS];
    int          high_mark;
    int          freed_count;

    // Results predicted but not yet seen on the output channel
    t_out_item   replies_due [$];
    int          errors;

    // Apply one command to the model and return the result it must give
    function automatic t_out_item apply_table_cmd(input t_in_item item);
        t_out_item res;
        int        slot;
        int        hnd;
        res  = '0;
        slot = 0;
        hnd  = int'(item.handle_index);
        case (item.cmd)
            CMD_STORE: begin
                if (freed_count > 0) begin
                    // LIFO reuse of the most recently released slot
                    freed_count--;
                    slot = int'(freed_slots[freed_count]);
                end else if (high_mark < SLOTS) begin
                    slot = high_mark;
                    high_mark++;
                end else begin
                    res.status = ST_FULL;
                    return res;
                end
                slot_words[slot] = item.entry_value;
                res.handle_out   = 11'(slot + 1);
                res.status       = ST_OK;
            end
            CMD_FIND, CMD_RELEASE: begin
                // Null, past the high-water mark, or an empty slot
                if (hnd == 0 || hnd > high_mark || slot_words[hnd - 1] == '0) begin
                    res.status = ST_NOT_FOUND;
                    return res;
                end
                res.handle_out = 11'(hnd);
                res.entry_out  = slot_words[hnd - 1];
                res.status     = ST_OK;
                if (item.cmd == CMD_RELEASE) begin
                    slot_words[hnd - 1]      = '0;
                    freed_slots[freed_count] = 10'(hnd - 1);
                    freed_count++;
                end
            end
            default: begin
                res.status = ST_NOT_FOUND;
            end
        endcase
        return res;
    endfunction

    // Sample both channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            high_mark   = 0;
            freed_count = 0;
            errors      = 0;
            replies_due.delete();
        end else begin
            // Result side first: it can never belong to an item taken this edge
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: handle_out %0d entry_out %h status %0d",
                             $time, i_out_item.handle_out, i_out_item.entry_out,
                             i_out_item.status);
                end else begin
                    want = replies_due.pop_front();
                    if (i_out_item.handle_out !== want.handle_out) begin
                        errors++;
                        $display("%0t handle_out mismatch: expected %0d actual %0d",
                                 $time, want.handle_out, i_out_item.handle_out);
                    end
                    if (i_out_item.entry_out !== want.entry_out) begin
                        errors++;
                        $display("%0t entry_out mismatch: expected %h actual %h",
                                 $time, want.entry_out, i_out_item.entry_out);
                    end
                    if (i_out_item.status !== want.status) begin
                        errors++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, i_out_item.status);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                replies_due.insert(replies_due.size(), apply_table_cmd(i_in_item));
            end
        end
        o_fail_count <= errors;
        o_pending    <= replies_due.size();
    end

endmodule

// ===== tb/handle_slot_table_core_test.sv =====
// ============================================================================
// Handle slot table testbench
// Directed items cover null, out-of-range and empty-slot handles, zero and
// all-ones entries, double release, LIFO slot reuse and the unused command
// code. Random traffic then runs under several idle and stall mixes plus one
// long receiver hold-off. The checker module does the scoring.
// ============================================================================
module handle_slot_table_core_test;
    import hst_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         SLOTS          = SLOT_COUNT_DEF;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         HOLD_CYCLES    = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        pending;

    // Stimulus knobs
    int        tx_idle_pct;
    int        rx_stall_pct;
    bit        rx_hold_req;
    int        stores_sent;
    int        quiet_cycles;

    handle_slot_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    handle_slot_table_core_check checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic t_in_item make_item(input logic [1:0] cmd, input int hnd,
                                           input logic [31:0] value);
        t_in_item it;
        it.cmd          = cmd;
        it.handle_index = 12'(hnd);
        it.entry_value  = value;
        return it;
    endfunction

    // Random command, handles biased toward slots that have been handed out
    function automatic t_in_item rand_item(input int used_est);
        int          r;
        int          hnd;
        logic [1:0]  cmd;
        logic [31:0] value;
        r = $urandom_range(0, 99);
        if (r < 40)      cmd = CMD_STORE;
        else if (r < 70) cmd = CMD_FIND;
        else if (r < 95) cmd = CMD_RELEASE;
        else             cmd = CMD_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 10)      hnd = 0;
        else if (r < 20) hnd = $urandom_range(0, 4095);
        else             hnd = $urandom_range(1, used_est + 1);
        r = $urandom_range(0, 99);
        if (r < 6)       value = '0;
        else if (r < 12) value = '1;
        else             value = $urandom;
        return make_item(cmd, hnd, value);
    endfunction

    // Offer one item, optionally after a random gap, and wait for acceptance
    task automatic issue(input t_in_item it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        if (it.cmd == CMD_STORE) stores_sent++;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) issue(rand_item(stores_sent > SLOTS ? SLOTS : stores_sent));
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            if (rx_hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles where neither channel moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("handle_slot_table_core_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main stimulus
    initial begin
        i_rst_n      <= 1'b0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b0;
        stores_sent  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, zero entry, reuse, double release
        issue(make_item(CMD_FIND,    0,    32'h0));
        issue(make_item(CMD_FIND,    1,    32'h0));
        issue(make_item(CMD_RELEASE, 1,    32'hFFFF_FFFF));
        issue(make_item(CMD_UNUSED,  4095, 32'hFFFF_FFFF));
        issue(make_item(CMD_STORE,   4095, 32'hFFFF_FFFF));
        issue(make_item(CMD_STORE,   0,    32'h0));
        issue(make_item(CMD_STORE,   0,    32'h1234_5678));
        issue(make_item(CMD_FIND,    1,    32'h0));
        issue(make_item(CMD_FIND,    2,    32'h0));
        issue(make_item(CMD_RELEASE, 2,    32'h0));
        issue(make_item(CMD_FIND,    4,    32'h0));
        issue(make_item(CMD_FIND,    4095, 32'h0));
        issue(make_item(CMD_RELEASE, 2048, 32'h0));
        issue(make_item(CMD_RELEASE, 3,    32'h0));
        issue(make_item(CMD_RELEASE, 3,    32'h0));
        issue(make_item(CMD_RELEASE, 1,    32'h0));
        issue(make_item(CMD_STORE,   0,    32'hA5A5_A5A5));
        issue(make_item(CMD_STORE,   0,    32'h5A5A_5A5A));
        issue(make_item(CMD_STORE,   0,    32'h0000_0001));
        issue(make_item(CMD_FIND,    4,    32'h0));
        issue(make_item(CMD_FIND,    3,    32'h0));
        issue(make_item(CMD_FIND,    1,    32'h0));

        // Random traffic under each idle and stall mix
        run_random(210, 0, 0);
        run_random(210, 62, 0);
        run_random(210, 0, 62);
        run_random(210, 34, 34);

        // Long receiver hold-off while the sender keeps offering
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b1;
        run_random(30, 0, 0);
        in_valid <= 1'b0;

        // Drain outstanding results, then allow a few more cycles
        rx_stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("handle_slot_table_core_test: clean");
        end else begin
            $display("handle_slot_table_core_test: errors");
        end
        $finish;
    end

endmodule
